// ===== src/memory_region_table_assert.svh =====
// Assertion macros for the memory region table.
// No dependencies; included by modules that carry assertions.
`ifndef MEMORY_REGION_TABLE_ASSERT_SVH
`define MEMORY_REGION_TABLE_ASSERT_SVH

// same-cycle implication
`define MRT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("memory region table assertion failed");

// next-cycle implication
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("memory region table assertion failed");

`endif

// ===== src/mrt_pkg.sv =====
// Shared types, codes and helpers of the memory region table.
// No dependencies.
package mrt_pkg;

  localparam int ADDR_W = 64;
  localparam int ID_W   = 32;
  localparam int CFG_W  = 19;
  localparam int OFF_W  = 16;

  typedef enum logic [1:0] {
    OP_ADD_AUTO = 2'd0,
    OP_ADD_ID   = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_CHECK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARGS = 2'd1,
    ST_BAD_ID   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] phys_base;
    logic [ADDR_W-1:0] region_len;
    logic [ID_W-1:0]   region_tag;
    logic [ADDR_W-1:0] buf_offset;
    logic [ADDR_W-1:0] buf_length;
    logic [ADDR_W-1:0] valid_start;
    logic [ADDR_W-1:0] valid_len;
  } req_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] assigned_id;
    logic            in_bounds;
  } rsp_t;

  // exact a + b <= c
  function automatic logic sum_le(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                                  logic [ADDR_W-1:0] c);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s <= {1'b0, c};
  endfunction

endpackage

// ===== src/mrt_req_if.sv =====
// Request channel of the memory region table.
// Depends on mrt_pkg.
interface mrt_req_if import mrt_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/mrt_rsp_if.sv =====
// Response channel of the memory region table.
// Depends on mrt_pkg.
interface mrt_rsp_if import mrt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/memory_region_table.sv =====
// Memory region table: one request at a time, one response per request.
// Add with assigned id: an overlap scan over every slot through the region RAM read
// port, then a probe for a free id (at most 2**clog2(POOL_SLOTS) ids are tried).
// Add with id, remove: no scan; bounds check: region length from the RAM read.
// Synchronous reset clears slot valid bits, count, probe offset and id_base;
// no clearing pass. Depends on mrt_pkg, mrt_req_if, mrt_rsp_if, mrt_ram.
`include "memory_region_table_assert.svh"

module memory_region_table import mrt_pkg::*; #(
  parameter int POOL_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  mrt_req_if.sink          req,
  mrt_rsp_if.source        rsp
);
  localparam int IW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int TW = IW + 1;
  localparam logic [ID_W-1:0] ID_MASK   = ID_W'(POOL_SLOTS - 1);
  localparam logic [CW-1:0]   SLOTS     = CW'(POOL_SLOTS);
  localparam logic [TW-1:0]   TRY_LIMIT = TW'(2 ** IW);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_PROBE, S_CHECK, S_DONE
  } state_t;

  state_t                state;
  req_t                  req_q;
  logic [CFG_W-1:0]      id_base;
  logic [POOL_SLOTS-1:0] used;
  logic [CW-1:0]         count;
  logic [OFF_W-1:0]      probe_off;
  logic [CW-1:0]         cnt;
  logic                  rd_used;
  logic                  reject;
  logic [ID_W-1:0]       pbase;
  logic [OFF_W-1:0]      trial;
  logic [TW-1:0]         tries;
  status_t               res_status;
  logic [ID_W-1:0]       res_assigned;
  logic                  res_inb;

  logic [IW-1:0]           idx;
  logic [IW-1:0]           probe_idx;
  logic [ID_W-1:0]         probe_id;
  logic [2*ADDR_W-1:0]     rdata;
  logic [ADDR_W-1:0]       rd_base;
  logic [ADDR_W-1:0]       rd_len;
  logic                    hit;
  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [IW-1:0]           ram_raddr;
  logic                    probe_free;

  assign idx       = IW'(req_q.region_tag & ID_MASK);
  assign probe_id  = pbase + {{(ID_W-OFF_W){1'b0}}, trial};
  assign probe_idx = IW'(probe_id & ID_MASK);
  assign rd_base   = rdata[2*ADDR_W-1:ADDR_W];
  assign rd_len    = rdata[ADDR_W-1:0];
  assign probe_free = (tries != TRY_LIMIT) && !used[probe_idx];

  assign hit = rd_used && ((rd_base == req_q.phys_base) ||
               !(sum_le(req_q.phys_base, req_q.region_len, rd_base) ||
                 sum_le(rd_base, rd_len, req_q.phys_base)));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    if (state == S_EXEC && req_q.operation == OP_ADD_ID && count < SLOTS && !used[idx]) begin
      ram_we = 1'b1;
    end else if (state == S_PROBE && probe_free) begin
      ram_we    = 1'b1;
      ram_waddr = probe_idx;
    end
  end

  assign ram_raddr = (state == S_SCAN) ? cnt[IW-1:0] : idx;
  assign req.ready = (state == S_IDLE);

  mrt_ram #(.WIDTH(2 * ADDR_W), .DEPTH(POOL_SLOTS)) u_region_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({req_q.phys_base, req_q.region_len}),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      id_base   <= '0;
      used      <= '0;
      count     <= '0;
      probe_off <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        id_base <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_q <= req.payload;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_assigned <= '0;
          res_inb      <= 1'b0;
          unique case (req_q.operation)
            OP_ADD_AUTO: begin
              res_status <= ST_OK;
              cnt        <= '0;
              rd_used    <= 1'b0;
              reject     <= 1'b0;
              state      <= S_SCAN;
            end
            OP_ADD_ID: begin
              state <= S_DONE;
              if (count >= SLOTS) begin
                res_status <= ST_FULL;
              end else if (used[idx]) begin
                res_status <= ST_BAD_ID;
              end else begin
                res_status <= ST_OK;
                used[idx]  <= 1'b1;
                count      <= count + CW'(1);
              end
            end
            OP_REMOVE: begin
              state <= S_DONE;
              if (!used[idx]) begin
                res_status <= ST_BAD_ID;
              end else begin
                res_status <= ST_OK;
                used[idx]  <= 1'b0;
                count      <= count - CW'(1);
              end
            end
            OP_CHECK: begin
              if (!used[idx]) begin
                res_status <= ST_BAD_ID;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_CHECK;
              end
            end
          endcase
        end
        S_CHECK: begin
          res_inb <= sum_le(req_q.buf_length, req_q.buf_offset, rd_len) &&
                     sum_le(req_q.valid_start, req_q.valid_len, req_q.buf_length);
          state   <= S_DONE;
        end
        S_SCAN: begin
          rd_used <= (cnt < SLOTS) && used[cnt[IW-1:0]];
          cnt     <= cnt + CW'(1);
          if (hit) begin
            reject <= 1'b1;
          end
          if (cnt == SLOTS) begin
            if (reject || hit) begin
              res_status <= ST_BAD_ARGS;
              state      <= S_DONE;
            end else if (count >= SLOTS) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              pbase <= ID_W'(id_base) + ID_W'(count) + ID_W'(1);
              trial <= probe_off;
              tries <= '0;
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (tries == TRY_LIMIT) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else if (probe_free) begin
            probe_off       <= trial;
            used[probe_idx] <= 1'b1;
            count           <= count + CW'(1);
            res_assigned    <= probe_id;
            state           <= S_DONE;
          end else begin
            trial <= trial + OFF_W'(1);
            tries <= tries + TW'(1);
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid               <= 1'b1;
            rsp.payload.status      <= res_status;
            rsp.payload.assigned_id <= res_assigned;
            rsp.payload.in_bounds   <= res_inb;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MRT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= SLOTS)
  `MRT_ASSERT_NOW(a_count_matches, clk, rst, 1'b1, $countones(used) == int'(count))
  `MRT_ASSERT_NOW(a_fail_clean, clk, rst, rsp.valid && rsp.payload.status != ST_OK,
                  rsp.payload.assigned_id == '0 && !rsp.payload.in_bounds)
  `MRT_ASSERT_NEXT(a_done_emits, clk, rst, state == S_DONE && (!rsp.valid || rsp.ready),
                   rsp.valid && state == S_IDLE)

endmodule

// ===== src/mrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
